@@ hdl/rpsd_pkg.sv @@
// Shared types and constants for the RV32I program store decoder.
// Holds opcode codes, format kinds, field-presence bits and the decode record.
// No dependencies.
package rpsd_pkg;

   localparam int WORD_W  = 32;
   localparam int INDEX_W = 10;
   localparam int MASK_W  = 6;

   // RV32I major opcodes
   localparam logic [6:0] OP_REG    = 7'h33;
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_IMM    = 7'h13;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_LUI    = 7'h37;
   localparam logic [6:0] OP_JALR   = 7'h67;
   localparam logic [6:0] OP_JAL    = 7'h6F;
   localparam logic [6:0] OP_AUIPC  = 7'h17;

   // request actions
   localparam logic ACT_APPEND = 1'b0;
   localparam logic ACT_FETCH  = 1'b1;

   // field-presence bits
   localparam logic [MASK_W-1:0] HAS_RD  = 6'h01;
   localparam logic [MASK_W-1:0] HAS_RS1 = 6'h02;
   localparam logic [MASK_W-1:0] HAS_RS2 = 6'h04;
   localparam logic [MASK_W-1:0] HAS_F3  = 6'h08;
   localparam logic [MASK_W-1:0] HAS_F7  = 6'h10;
   localparam logic [MASK_W-1:0] HAS_IMM = 6'h20;

   typedef enum logic [2:0] {
      KIND_U   = 3'd0,
      KIND_J   = 3'd1,
      KIND_I   = 3'd2,
      KIND_B   = 3'd3,
      KIND_S   = 3'd4,
      KIND_R   = 3'd5,
      KIND_BRK = 3'd6
   } kind_type;

   typedef struct packed {
      kind_type                 kind;
      logic [6:0]               opcode;
      logic [4:0]               dest_reg;
      logic [4:0]               src1_reg;
      logic [4:0]               src2_reg;
      logic [2:0]               funct_three;
      logic [6:0]               funct_seven;
      logic signed [WORD_W-1:0] immediate;
      logic [MASK_W-1:0]        present_mask;
      logic [WORD_W-1:0]        raw_word;
      logic                     out_of_range;
   } decode_type;

endpackage

@@ hdl/rv32i_program_store_decoder_core.sv @@
// RV32I program store and decoder, top level.
// A fetch transaction shows its result through the RAM read register, then the
// output register; appends give no result.
// Throughput: one transaction per cycle, set by the single read port, except while both stages stall.
// Reset clears the loaded count and the pipeline valids; store contents stay
// undefined, and slots at or past the loaded count report out of range.
module rv32i_program_store_decoder_core #(
   parameter int STORE_DEPTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_action,
   input  logic [rpsd_pkg::INDEX_W-1:0]       req_index,
   input  logic [rpsd_pkg::WORD_W-1:0]        req_word,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [2:0]                         rsp_kind,
   output logic [6:0]                         rsp_opcode,
   output logic [4:0]                         rsp_dest_reg,
   output logic [4:0]                         rsp_src1_reg,
   output logic [4:0]                         rsp_src2_reg,
   output logic [2:0]                         rsp_funct_three,
   output logic [6:0]                         rsp_funct_seven,
   output logic signed [rpsd_pkg::WORD_W-1:0] rsp_immediate,
   output logic [rpsd_pkg::MASK_W-1:0]        rsp_present_mask,
   output logic [rpsd_pkg::WORD_W-1:0]        rsp_raw_word,
   output logic                               rsp_out_of_range
);
   import rpsd_pkg::*;

   localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
   localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              rd_valid_ff;
   logic              rd_valid_in;
   logic              rd_oor_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   decode_type        rsp_data_ff;
   decode_type        dec_result;
   logic [WORD_W-1:0] ram_rdata;

   logic              req_fire;
   logic              do_append;
   logic              do_fetch;
   logic              store_full;
   logic              index_oor;
   logic              rd_advance;

   assign req_fire   = req_valid && req_ready;
   assign do_append  = req_fire && (req_action == ACT_APPEND) && !store_full;
   assign do_fetch   = req_fire && (req_action == ACT_FETCH);
   assign store_full = (count_ff == CNT_W'(STORE_DEPTH));
   assign index_oor  = (CMP_W'(req_index) >= CMP_W'(count_ff)) ||
                       (CMP_W'(req_index) >= CMP_W'(STORE_DEPTH));

   // move the read stage on when the output register is free or draining
   assign rd_advance = rd_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !rd_valid_ff || !rsp_valid_ff || rsp_ready;

   assign count_in     = do_append ? count_ff + CNT_W'(1) : count_ff;
   assign rd_valid_in  = do_fetch || (rd_valid_ff && !rd_advance);
   assign rsp_valid_in = rd_advance || (rsp_valid_ff && !rsp_ready);

   rpsd_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (do_append),
      .wr_addr (ADDR_W'(count_ff)),
      .wr_data (req_word),
      .rd_en   (do_fetch && !index_oor),
      .rd_addr (ADDR_W'(CMP_W'(req_index))),
      .rd_data (ram_rdata)
   );

   rpsd_decode u_decode (
      .word         (ram_rdata),
      .out_of_range (rd_oor_ff),
      .result       (dec_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_fetch) begin
         rd_oor_ff <= index_oor;
      end
      if (rd_advance) begin
         rsp_data_ff <= dec_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_data_ff.kind;
   assign rsp_opcode       = rsp_data_ff.opcode;
   assign rsp_dest_reg     = rsp_data_ff.dest_reg;
   assign rsp_src1_reg     = rsp_data_ff.src1_reg;
   assign rsp_src2_reg     = rsp_data_ff.src2_reg;
   assign rsp_funct_three  = rsp_data_ff.funct_three;
   assign rsp_funct_seven  = rsp_data_ff.funct_seven;
   assign rsp_immediate    = rsp_data_ff.immediate;
   assign rsp_present_mask = rsp_data_ff.present_mask;
   assign rsp_raw_word     = rsp_data_ff.raw_word;
   assign rsp_out_of_range = rsp_data_ff.out_of_range;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STORE_DEPTH))
      else $error("loaded count past store depth");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_action == ACT_APPEND && store_full) |=> $stable(count_ff))
      else $error("append into full store changed the count");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rd_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request taken while both stages are stalled");

   a_fetch_enters: assert property (@(posedge clock) disable iff (reset)
      do_fetch |=> rd_valid_ff)
      else $error("accepted fetch did not enter the read stage");

   a_oor_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |->
         (rsp_kind == KIND_BRK && rsp_present_mask == '0))
      else $error("out-of-range result carries decoded fields");

endmodule

@@ hdl/rpsd_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stands alone; read data holds while no read is enabled.
module rpsd_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

@@ hdl/rpsd_decode.sv @@
// RV32I field decoder: splits a stored word into format kind, register fields
// and the sign-extended immediate. Depends on rpsd_pkg.
module rpsd_decode (
   input  logic [rpsd_pkg::WORD_W-1:0] word,
   input  logic                        out_of_range,
   output rpsd_pkg::decode_type        result
);
   import rpsd_pkg::*;

   logic [6:0]        opcode;
   kind_type          kind;
   logic [MASK_W-1:0] mask;
   logic [WORD_W-1:0] imm_i;
   logic [WORD_W-1:0] imm_s;
   logic [WORD_W-1:0] imm_b;
   logic [WORD_W-1:0] imm_u;
   logic [WORD_W-1:0] imm_j;
   logic [WORD_W-1:0] imm_sel;

   assign opcode = word[6:0];
   assign imm_i  = {{20{word[31]}}, word[31:20]};
   assign imm_s  = {{20{word[31]}}, word[31:25], word[11:7]};
   assign imm_b  = {{20{word[31]}}, word[7], word[30:25], word[11:8], 1'b0};
   assign imm_u  = {word[31:12], 12'h000};
   assign imm_j  = {{12{word[31]}}, word[19:12], word[20], word[30:21], 1'b0};

   always_comb begin
      case (opcode)
         OP_REG: begin
            kind    = KIND_R;
            mask    = HAS_RD | HAS_RS1 | HAS_RS2 | HAS_F3 | HAS_F7;
            imm_sel = '0;
         end
         OP_LOAD, OP_IMM, OP_JALR: begin
            kind    = KIND_I;
            mask    = HAS_RD | HAS_RS1 | HAS_F3 | HAS_IMM;
            imm_sel = imm_i;
         end
         OP_STORE: begin
            kind    = KIND_S;
            mask    = HAS_RS1 | HAS_RS2 | HAS_F3 | HAS_IMM;
            imm_sel = imm_s;
         end
         OP_BRANCH: begin
            kind    = KIND_B;
            mask    = HAS_RS1 | HAS_RS2 | HAS_F3 | HAS_IMM;
            imm_sel = imm_b;
         end
         OP_LUI, OP_AUIPC: begin
            kind    = KIND_U;
            mask    = HAS_RD | HAS_IMM;
            imm_sel = imm_u;
         end
         OP_JAL: begin
            kind    = KIND_J;
            mask    = HAS_RD | HAS_IMM;
            imm_sel = imm_j;
         end
         default: begin
            kind    = KIND_BRK;
            mask    = '0;
            imm_sel = '0;
         end
      endcase
   end

   always_comb begin
      result = '0;
      result.kind         = KIND_BRK;
      result.out_of_range = out_of_range;
      if (!out_of_range) begin
         result.kind         = kind;
         result.opcode       = opcode;
         result.raw_word     = word;
         result.present_mask = mask;
         result.immediate    = imm_sel;
         // zero fields the format leaves undefined
         result.dest_reg     = (|(mask & HAS_RD))  ? word[11:7]  : 5'd0;
         result.src1_reg     = (|(mask & HAS_RS1)) ? word[19:15] : 5'd0;
         result.src2_reg     = (|(mask & HAS_RS2)) ? word[24:20] : 5'd0;
         result.funct_three  = (|(mask & HAS_F3))  ? word[14:12] : 3'd0;
         result.funct_seven  = (|(mask & HAS_F7))  ? word[31:25] : 7'd0;
      end
   end

endmodule
